@@ src/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off while reset is asserted
`define ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, held off while reset is asserted
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ src/imadec_pkg.sv @@
// types, constants and nibble decode function for the ima adpcm decoder
package imadec_pkg;

    // action codes of an input word
    localparam logic [1:0] ACT_RESTART      = 2'd0;
    localparam logic [1:0] ACT_RESTART_EMIT = 2'd1;
    localparam logic [1:0] ACT_DECODE       = 2'd2;
    localparam logic [1:0] ACT_NONE         = 2'd3;

    localparam logic [6:0]        MAX_INDEX     = 7'd88;
    localparam logic signed [7:0] MAX_INDEX_S   = 8'sd88;
    localparam logic [15:0]       LOW_BYTE_MASK = 16'hFF00;
    localparam logic signed [17:0] SAMPLE_MIN   = -18'sd32768;
    localparam logic signed [17:0] SAMPLE_MAX   = 18'sd32767;
    localparam logic [3:0]        FIFO_DEPTH    = 4'd4;

    localparam logic [14:0] STEP_TABLE [0:88] = '{
        15'd7,     15'd8,     15'd9,     15'd10,    15'd11,    15'd12,    15'd13,
        15'd14,    15'd16,    15'd17,    15'd19,    15'd21,    15'd23,    15'd25,
        15'd28,    15'd31,    15'd34,    15'd37,    15'd41,    15'd45,    15'd50,
        15'd55,    15'd60,    15'd66,    15'd73,    15'd80,    15'd88,    15'd97,
        15'd107,   15'd118,   15'd130,   15'd143,   15'd157,   15'd173,   15'd190,
        15'd209,   15'd230,   15'd253,   15'd279,   15'd307,   15'd337,   15'd371,
        15'd408,   15'd449,   15'd494,   15'd544,   15'd598,   15'd658,   15'd724,
        15'd796,   15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,  15'd1411,
        15'd1552,  15'd1707,  15'd1878,  15'd2066,  15'd2272,  15'd2499,  15'd2749,
        15'd3024,  15'd3327,  15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,
        15'd5894,  15'd6484,  15'd7132,  15'd7845,  15'd8630,  15'd9493,  15'd10442,
        15'd11487, 15'd12635, 15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350,
        15'd22385, 15'd24623, 15'd27086, 15'd29794, 15'd32767
    };

    // predictor and step index of one channel
    typedef struct packed {
        logic signed [15:0] pred;
        logic [6:0]         index;
    } nib_state_t;

    // one output word
    typedef struct packed {
        logic signed [15:0] sample;
        logic               channel;
        logic               last;
    } out_word_t;

    function automatic logic signed [4:0] index_adjust(input logic [2:0] mag);
        logic signed [4:0] adj;
        unique case (mag)
            3'd4:    adj = 5'sd2;
            3'd5:    adj = 5'sd4;
            3'd6:    adj = 5'sd6;
            3'd7:    adj = 5'sd8;
            default: adj = -5'sd1;
        endcase
        return adj;
    endfunction

    function automatic nib_state_t decode_nibble(input nib_state_t cur, input logic [3:0] nib);
        logic [6:0]         idx;
        logic [14:0]        step;
        logic [15:0]        diff;
        logic signed [17:0] delta;
        logic signed [17:0] sum;
        logic signed [7:0]  ni;
        nib_state_t         res;
        idx  = (cur.index > MAX_INDEX) ? MAX_INDEX : cur.index;
        step = STEP_TABLE[idx];
        diff = {4'b0, step[14:3]};
        if (nib[2]) diff = diff + {1'b0, step};
        if (nib[1]) diff = diff + {2'b0, step[14:1]};
        if (nib[0]) diff = diff + {3'b0, step[14:2]};
        delta = $signed({2'b0, diff});
        if (nib[3]) delta = -delta;
        sum = $signed({{2{cur.pred[15]}}, cur.pred}) + delta;
        if (sum < SAMPLE_MIN)      res.pred = -16'sd32768;
        else if (sum > SAMPLE_MAX) res.pred = 16'sd32767;
        else                       res.pred = sum[15:0];
        ni = $signed({1'b0, idx}) + 8'(index_adjust(nib[2:0]));
        if (ni < 8'sd0)             res.index = 7'd0;
        else if (ni > MAX_INDEX_S)  res.index = MAX_INDEX;
        else                        res.index = ni[6:0];
        return res;
    endfunction

    // clear the low byte in 8-bit output mode
    function automatic logic signed [15:0] apply_mode(input logic signed [15:0] s,
                                                      input logic eight_bit);
        return eight_bit ? (s & LOW_BYTE_MASK) : s;
    endfunction

endpackage

@@ src/ima_adpcm_nibble_decoder_unit.sv @@
// top level of the ima adpcm 4-bit nibble decoder
// usage
//   input channel: in_valid / in_stall with action, channel, data_byte, nibble_count,
//   start_predictor, start_index and last_in_block. a word is taken at a rising edge
//   with in_valid high and in_stall low.
//   output channel: out_valid / out_stall with sample, sample_channel and last, one
//   decoded sample per word. a restart-with-emit yields one word, a data word up to
//   two (low nibble first), a silent restart or an ignored word none.
//   config channel: cfg_valid / cfg_ready with cfg_data (8-bit output mode); cfg_ready
//   is always high, write only while the decoder is idle.
// timing
//   an input word lands in an input register, then one combinational pass (two
//   chained nibble updates) writes its results into a 4-entry output queue.
//   the first result goes from the input register into the queue before it is on
//   the output. one input word per cycle as long as the queue has room; the output
//   side moves one sample per cycle while out_stall is low, so a stream of
//   two-nibble words is limited by the output side.
// reset: predictors, step indexes, 8-bit mode and the queue clear at once.
// stall: a stalled output word holds; when the queue cannot take the results of the
//   registered word, in_stall rises until it drains.
module ima_adpcm_nibble_decoder_unit #(
    parameter int CHANNELS = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          action,
    input  logic                channel,
    input  logic [7:0]          data_byte,
    input  logic [1:0]          nibble_count,
    input  logic signed [15:0]  start_predictor,
    input  logic [7:0]          start_index,
    input  logic                last_in_block,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [15:0]  sample,
    output logic                sample_channel,
    output logic                last,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data
);
    import imadec_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [1:0] CH_LIMIT = 2'(CHANNELS);

    // config register
    logic eight_bit_reg;

    // input register stage
    logic               s1_valid_reg;
    logic [1:0]         s1_action_reg;
    logic               s1_channel_reg;
    logic [7:0]         s1_byte_reg;
    logic [1:0]         s1_count_reg;
    logic signed [15:0] s1_pred_reg;
    logic [7:0]         s1_index_reg;
    logic               s1_last_reg;

    // per-channel decoder state
    logic signed [15:0] pred_reg [CHANNELS];
    logic [6:0]         index_reg [CHANNELS];

    // output queue
    out_word_t  fifo_mem_reg [4];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] count_reg, count_next;

    logic       in_take, s1_advance, pop, push0, push1, chan_ok, state_we;
    logic [CH_W-1:0] ch_idx;
    logic [1:0] n_results;
    nib_state_t cur_st, first_st, second_st, restart_st, next_st;
    out_word_t  w0, w1;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            eight_bit_reg <= 1'b0;
        else if (cfg_valid && cfg_ready)
            eight_bit_reg <= cfg_data;
    end

    // input stage: hold the word until its results fit in the queue
    assign in_stall = s1_valid_reg && !s1_advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_take)
            s1_valid_reg <= 1'b1;
        else if (s1_advance)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_action_reg  <= action;
            s1_channel_reg <= channel;
            s1_byte_reg    <= data_byte;
            s1_count_reg   <= nibble_count;
            s1_pred_reg    <= start_predictor;
            s1_index_reg   <= start_index;
            s1_last_reg    <= last_in_block;
        end
    end

    // decode pass
    assign ch_idx  = CH_W'(s1_channel_reg);
    assign chan_ok = {1'b0, s1_channel_reg} < CH_LIMIT;

    always_comb
    begin
        cur_st.pred      = pred_reg[ch_idx];
        cur_st.index     = index_reg[ch_idx];
        first_st         = decode_nibble(cur_st, s1_byte_reg[3:0]);
        second_st        = decode_nibble(first_st, s1_byte_reg[7:4]);
        restart_st.pred  = s1_pred_reg;
        restart_st.index = (s1_index_reg > {1'b0, MAX_INDEX}) ? MAX_INDEX : s1_index_reg[6:0];

        next_st   = cur_st;
        state_we  = 1'b0;
        n_results = 2'd0;
        w0.sample  = apply_mode(first_st.pred, eight_bit_reg);
        w0.channel = s1_channel_reg;
        w0.last    = s1_last_reg;
        w1.sample  = apply_mode(second_st.pred, eight_bit_reg);
        w1.channel = s1_channel_reg;
        w1.last    = s1_last_reg;

        if (s1_valid_reg && chan_ok)
        begin
            unique case (s1_action_reg)
                ACT_RESTART:
                begin
                    state_we = 1'b1;
                    next_st  = restart_st;
                end
                ACT_RESTART_EMIT:
                begin
                    state_we  = 1'b1;
                    next_st   = restart_st;
                    n_results = 2'd1;
                    w0.sample = apply_mode(s1_pred_reg, eight_bit_reg);
                end
                ACT_DECODE:
                begin
                    unique case (s1_count_reg)
                        2'd0: ;
                        2'd1:
                        begin
                            state_we  = 1'b1;
                            next_st   = first_st;
                            n_results = 2'd1;
                        end
                        default:
                        begin
                            // odd tail excluded: both nibbles, last only on the second
                            state_we  = 1'b1;
                            next_st   = second_st;
                            n_results = 2'd2;
                            w0.last   = 1'b0;
                        end
                    endcase
                end
                ACT_NONE: ;
            endcase
        end
    end

    assign s1_advance = s1_valid_reg &&
                        (({1'b0, count_reg} + {2'b0, n_results}) <= FIFO_DEPTH);
    assign push0 = s1_advance && (n_results != 2'd0);
    assign push1 = s1_advance && (n_results == 2'd2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                pred_reg[i]  <= '0;
                index_reg[i] <= '0;
            end
        end
        else if (s1_advance && state_we)
        begin
            pred_reg[ch_idx]  <= next_st.pred;
            index_reg[ch_idx] <= next_st.index;
        end
    end

    // output queue
    assign out_valid      = count_reg != 3'd0;
    assign pop            = out_valid && !out_stall;
    assign sample         = fifo_mem_reg[rd_ptr_reg].sample;
    assign sample_channel = fifo_mem_reg[rd_ptr_reg].channel;
    assign last           = fifo_mem_reg[rd_ptr_reg].last;

    assign count_next = count_reg + {2'b0, push0} + {2'b0, push1} - {2'b0, pop};

    always_ff @(posedge clk)
    begin
        if (push0)
            fifo_mem_reg[wr_ptr_reg] <= w0;
        if (push1)
            fifo_mem_reg[wr_ptr_reg + 2'd1] <= w1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + {1'b0, push0} + {1'b0, push1};
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            count_reg <= count_next;
        end
    end

endmodule

@@ src/imadec_checker.sv @@
// port-level assertions for the ima adpcm decoder and their bind
`include "assert_macros.svh"

module imadec_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic [1:0]          action,
    input logic                channel,
    input logic [7:0]          data_byte,
    input logic [1:0]          nibble_count,
    input logic signed [15:0]  start_predictor,
    input logic [7:0]          start_index,
    input logic                last_in_block,
    input logic                out_valid,
    input logic                out_stall,
    input logic signed [15:0]  sample,
    input logic                sample_channel,
    input logic                last,
    input logic                cfg_valid,
    input logic                cfg_ready,
    input logic                cfg_data
);
    import imadec_pkg::*;

    // shadow of the 8-bit output mode
    logic mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= 1'b0;
        else if (cfg_valid && cfg_ready)
            mode_reg <= cfg_data;
    end

    // input backs up only while the output queue holds a sample
    `ASSERT_IMPLY(a_stall_needs_output, clk, rst_n, in_stall, out_valid)

    // input stall starts only right after a word was taken
    `ASSERT_IMPLY(a_stall_after_take, clk, rst_n, $rose(in_stall), $past(in_valid))

    // 8-bit mode clears the low byte of every sample
    `ASSERT_IMPLY(a_eight_bit_low_clear, clk, rst_n, out_valid && mode_reg,
                  (sample & ~LOW_BYTE_MASK) == 16'sd0)

    // a stalled sample stays in place
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
                 out_valid && $stable(sample) && $stable(sample_channel) && $stable(last))

    // a stalled input word stays in place
    `ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && in_stall,
                 in_valid && $stable(action) && $stable(channel) && $stable(data_byte)
                 && $stable(nibble_count) && $stable(start_predictor)
                 && $stable(start_index) && $stable(last_in_block))

endmodule

bind ima_adpcm_nibble_decoder_unit imadec_checker u_imadec_checker (.*);
